[hdl/pctd_pkg.sv]
// Shared constants, codes and transfer types for the prefix code table decoder.
package pctd_pkg;

  localparam int TableDepth = 256;
  localparam int MaxCodeLen = 16;

  localparam int IdxW   = $clog2(TableDepth);
  localparam int LimW   = $clog2(TableDepth + 1);
  localparam int PendCw = $clog2(MaxCodeLen + 1);

  localparam int FuncW    = 2;
  localparam int SymW     = 8;
  localparam int LenW     = 5;
  localparam int CodeW    = 16;
  localparam int EntIdxW  = 8;
  localparam int StatusW  = 2;
  localparam int EntriesW = 9;

  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  localparam logic [FuncW-1:0] FuncLoad = 2'd0;
  localparam logic [FuncW-1:0] FuncBit  = 2'd1;
  localparam logic [FuncW-1:0] FuncEnd  = 2'd2;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusOverlong = 2'd1;
  localparam logic [StatusW-1:0] StatusLeftover = 2'd2;

  localparam int RegEntriesInUse = 0;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [EntIdxW-1:0] entry_index;
    logic [SymW-1:0]    entry_symbol;
    logic [LenW-1:0]    entry_length;
    logic [CodeW-1:0]   entry_code;
    logic               bit_value;
  } in_t;

  typedef struct packed {
    logic [SymW-1:0]    symbol;
    logic [StatusW-1:0] status;
  } out_t;

  typedef struct packed {
    logic [SymW-1:0]  symbol;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
  } slot_t;

endpackage

[hdl/pctd_apb_regs.sv]
// APB register block holding the count of table entries that are searched.
module pctd_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pctd_pkg::PaddrW-1:0]  paddr,
  input  logic [pctd_pkg::PdataW-1:0]  pwdata,
  output logic [pctd_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output logic [pctd_pkg::EntriesW-1:0] entries_o
);

  logic [pctd_pkg::EntriesW-1:0] entries_q, entries_d;
  logic                          sel_entries;
  logic                          wr_en;

  // Registers sit on 32-bit words; the word index is the address above bit 1.
  assign sel_entries = (int'(paddr[pctd_pkg::PaddrW-1:2]) == pctd_pkg::RegEntriesInUse);
  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && pready;

  always_comb begin
    entries_d = entries_q;
    if (wr_en && sel_entries) begin
      entries_d = pwdata[pctd_pkg::EntriesW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else begin
      entries_q <= entries_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_entries) begin
      prdata = pctd_pkg::PdataW'(entries_q);
    end
  end

  assign entries_o = entries_q;

endmodule

[hdl/prefix_code_table_decoder.sv]
// Prefix code decoder: loaded slot table in a synchronous RAM, searched once per code bit.
// A code bit starts a search of N = min(entries_in_use, 256) slots, reading the slot RAM one
// slot per cycle and ending early on a match; no new transfer is taken until the search ends.
// A result is registered; while the output register is still full it waits in StEmit.
// Reset clears the pending bits, the entry count and the output; the slot RAM is not cleared
// and holds unknown data until loaded.
module prefix_code_table_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pctd_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pctd_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pctd_pkg::PaddrW-1:0]   paddr,
  input  logic [pctd_pkg::PdataW-1:0]   pwdata,
  output logic [pctd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StEmit
  } state_e;

  state_e                          state_q, state_d;
  logic [pctd_pkg::MaxCodeLen-1:0] pend_q, pend_d;
  logic [pctd_pkg::PendCw-1:0]     cnt_q, cnt_d;
  logic [pctd_pkg::IdxW-1:0]       idx_q, idx_d;
  pctd_pkg::out_t                  res_q, res_d;
  pctd_pkg::out_t                  out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic [pctd_pkg::EntriesW-1:0]   entries;
  logic [pctd_pkg::LimW-1:0]       limit;
  logic [pctd_pkg::LimW-1:0]       idx_next;
  logic [pctd_pkg::PendCw-1:0]     cnt_inc;
  logic [pctd_pkg::CodeW-1:0]      len_mask;
  logic                            slot_hit;
  logic                            in_xfer;
  logic                            res_go;
  pctd_pkg::out_t                  res;

  pctd_pkg::slot_t                 mem [pctd_pkg::TableDepth];
  pctd_pkg::slot_t                 rd_q;
  pctd_pkg::slot_t                 wr_data;
  logic                            wr_en;
  logic [pctd_pkg::IdxW-1:0]       wr_addr;
  logic [pctd_pkg::IdxW-1:0]       rd_addr;

  pctd_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .entries_o (entries)
  );

  always_comb begin
    if (int'(entries) > pctd_pkg::TableDepth) begin
      limit = pctd_pkg::LimW'(pctd_pkg::TableDepth);
    end else begin
      limit = pctd_pkg::LimW'(entries);
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign idx_next   = pctd_pkg::LimW'(idx_q) + pctd_pkg::LimW'(1);
  assign cnt_inc    = cnt_q + pctd_pkg::PendCw'(1);

  // The slot under test came from the RAM read issued in the previous cycle.
  assign len_mask = ~({pctd_pkg::CodeW{1'b1}} << rd_q.length);
  assign slot_hit = (rd_q.length != '0)
                 && (int'(rd_q.length) <= pctd_pkg::MaxCodeLen)
                 && (int'(rd_q.length) == int'(cnt_q))
                 && (32'(rd_q.code & len_mask) == 32'(pend_q));

  assign wr_addr = in_data_i.entry_index[pctd_pkg::IdxW-1:0];
  assign wr_data = '{symbol: in_data_i.entry_symbol,
                     length: in_data_i.entry_length,
                     code:   in_data_i.entry_code};

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_go      = 1'b0;
    res         = '0;
    wr_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          unique case (in_data_i.func)
            pctd_pkg::FuncLoad: begin
              wr_en = (int'(in_data_i.entry_index) < pctd_pkg::TableDepth);
            end
            pctd_pkg::FuncBit: begin
              pend_d = {pend_q[pctd_pkg::MaxCodeLen-2:0], in_data_i.bit_value};
              cnt_d  = cnt_inc;
              if (limit == '0) begin
                if (int'(cnt_inc) >= pctd_pkg::MaxCodeLen) begin
                  res_go     = 1'b1;
                  res.status = pctd_pkg::StatusOverlong;
                  pend_d     = '0;
                  cnt_d      = '0;
                end
              end else begin
                idx_d   = '0;
                rd_addr = '0;
                state_d = StSearch;
              end
            end
            pctd_pkg::FuncEnd: begin
              if (cnt_q != '0) begin
                res_go     = 1'b1;
                res.status = pctd_pkg::StatusLeftover;
                pend_d     = '0;
                cnt_d      = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StSearch: begin
        if (slot_hit) begin
          res_go     = 1'b1;
          res.symbol = rd_q.symbol;
          res.status = pctd_pkg::StatusOk;
          pend_d     = '0;
          cnt_d      = '0;
          state_d    = StIdle;
        end else if (idx_next == limit) begin
          state_d = StIdle;
          if (int'(cnt_q) >= pctd_pkg::MaxCodeLen) begin
            res_go     = 1'b1;
            res.status = pctd_pkg::StatusOverlong;
            pend_d     = '0;
            cnt_d      = '0;
          end
        end else begin
          idx_d   = idx_next[pctd_pkg::IdxW-1:0];
          rd_addr = idx_next[pctd_pkg::IdxW-1:0];
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A new result goes straight to the output register when it is free or draining.
    if (res_go) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end else begin
        res_d   = res;
        state_d = StEmit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Slot RAM: one write port for loads, one registered read port for the search.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idle_cnt_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> int'(cnt_q) < pctd_pkg::MaxCodeLen)
    else $error("pending count reached the maximum code length while idle");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> pctd_pkg::LimW'(idx_q) < limit)
    else $error("search index beyond the searched entries");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.func == pctd_pkg::FuncEnd && cnt_q != '0
    |=> (out_valid_o || state_q == StEmit) && cnt_q == '0)
    else $error("end of message with pending bits gave no result");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> out_valid_q)
    else $error("result held back while the output register was free");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the prefix code table decoder: directed and random code streams.
`timescale 1ns / 1ps

module testbench;
  import pctd_pkg::*;

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 300;
  localparam int RandomItems = 1600;
  localparam logic [PaddrW-1:0] EntriesAddr = PaddrW'(4 * RegEntriesInUse);
  // The one function code that the decoder leaves unused.
  localparam logic [FuncW-1:0]  FuncUnused  = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [PdataW-1:0]  pwdata = '0;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  // Shadow of the decoder state used to predict each output.
  logic [SymW-1:0]    tbl_sym  [TableDepth];
  logic [LenW-1:0]    tbl_len  [TableDepth];
  logic [CodeW-1:0]   tbl_code [TableDepth];
  logic [CodeW-1:0]   pend_bits = '0;
  int                 pend_cnt = 0;
  int unsigned        entries_cfg = 0;

  // Intended code of each slot, used to build well-formed streams.
  int                 want_len  [TableDepth];
  int                 want_code [TableDepth];

  out_t               decode_results_q[$];
  bit                 steady = 1'b0;
  int                 items_sent = 0;
  int                 results_checked = 0;
  int                 table_settings = 0;
  int                 errors = 0;
  int                 stall_cycles = 0;

  prefix_code_table_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    if (errors < 10) begin
      $display("mismatch: %s", msg);
    end
    errors++;
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when it yields an output.
  function automatic bit decode_item(input in_t item, output out_t res);
    int unsigned  limit;
    logic [CodeW:0] m;
    bit           found;
    found = 1'b0;
    res = '0;
    case (item.func)
      FuncLoad: begin
        tbl_sym[item.entry_index]  = item.entry_symbol;
        tbl_len[item.entry_index]  = item.entry_length;
        tbl_code[item.entry_index] = item.entry_code;
      end
      FuncBit: begin
        limit = (entries_cfg > TableDepth) ? TableDepth : entries_cfg;
        pend_bits = {pend_bits[CodeW-2:0], item.bit_value};
        pend_cnt++;
        for (int k = 0; k < limit; k++) begin
          if (!found && tbl_len[k] != 0 && tbl_len[k] <= MaxCodeLen &&
              tbl_len[k] == pend_cnt) begin
            m = ({{CodeW{1'b0}}, 1'b1} << tbl_len[k]) - 1'b1;
            if (({1'b0, tbl_code[k]} & m) == {1'b0, pend_bits}) begin
              found = 1'b1;
              res.symbol = tbl_sym[k];
              res.status = StatusOk;
            end
          end
        end
        if (!found && pend_cnt >= MaxCodeLen) begin
          found = 1'b1;
          res.status = StatusOverlong;
        end
        if (found) begin
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
      FuncEnd: begin
        if (pend_cnt != 0) begin
          found = 1'b1;
          res.status = StatusLeftover;
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
      default: ;
    endcase
    return found;
  endfunction

  function automatic in_t random_item(input logic [FuncW-1:0] f);
    in_t item;
    item.func         = f;
    item.entry_index  = EntIdxW'($urandom);
    item.entry_symbol = SymW'($urandom);
    item.entry_length = LenW'($urandom);
    item.entry_code   = CodeW'($urandom);
    item.bit_value    = 1'($urandom);
    return item;
  endfunction

  task automatic send_item(input in_t item);
    out_t res;
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (decode_item(item, res)) begin
      decode_results_q.push_back(res);
    end
    items_sent++;
  endtask

  task automatic send_load(input int idx, input int sym, input int len, input int code);
    in_t item;
    item = random_item(FuncLoad);
    item.entry_index  = EntIdxW'(idx);
    item.entry_symbol = SymW'(sym);
    item.entry_length = LenW'(len);
    item.entry_code   = CodeW'(code);
    send_item(item);
  endtask

  task automatic send_bit(input int b);
    in_t item;
    item = random_item(FuncBit);
    item.bit_value = 1'(b);
    send_item(item);
  endtask

  task automatic send_end();
    send_item(random_item(FuncEnd));
  endtask

  task automatic send_unused();
    send_item(random_item(FuncUnused));
  endtask

  // Holds the sender off until every output has arrived and the last search is over.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decode_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_entries(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EntriesAddr;
    pwdata  <= PdataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entries_cfg = value & 32'h1FF;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // Read the register back.
    psel    <= 1'b1;
    paddr   <= EntriesAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PdataW'(entries_cfg)) begin
      note_failure($sformatf("entries_in_use read exp %0d got %0h", entries_cfg, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    table_settings++;
  endtask

  // Loads n slots with a random prefix code, then decodes a mostly well-formed stream.
  task automatic run_phase(input int n, input int unsigned entries, input int budget);
    int lcode[$];
    int llen[$];
    int pick;
    int c;
    int l;
    int j;
    int t;
    int r;
    int start;
    int len;
    int code;
    lcode = {0};
    llen  = {0};
    while (lcode.size() < ((n < 2) ? 2 : n)) begin
      // Splitting the newest leaf often grows long codes.
      if ($urandom_range(99) < 40) begin
        pick = lcode.size() - 1;
      end else begin
        pick = $urandom_range(lcode.size() - 1);
      end
      if (llen[pick] < MaxCodeLen) begin
        c = lcode[pick];
        l = llen[pick];
        lcode[pick] = c << 1;
        llen[pick]  = l + 1;
        lcode.push_back((c << 1) | 1);
        llen.push_back(l + 1);
      end
    end
    for (int i = lcode.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = lcode[i]; lcode[i] = lcode[j]; lcode[j] = t;
      t = llen[i];  llen[i]  = llen[j];  llen[j]  = t;
    end
    for (int s = 0; s < n; s++) begin
      want_len[s]  = llen[s];
      want_code[s] = lcode[s];
      len  = llen[s];
      code = lcode[s] | ($urandom << len);
      r = $urandom_range(99);
      if (r < 4) begin
        len = 0;
      end else if (r < 8) begin
        len = $urandom_range(31, MaxCodeLen + 1);
      end else if (r < 12 && s > 0) begin
        // Same code as an earlier slot: the lower slot must win.
        j = $urandom_range(s - 1);
        len  = tbl_len[j];
        code = tbl_code[j];
      end
      send_load(s, $urandom, len, code);
    end
    settle();
    program_entries(entries);
    start = items_sent;
    while (items_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 75) begin
        j = $urandom_range(n - 1);
        for (int b = want_len[j] - 1; b >= 0; b--) begin
          send_bit((want_code[j] >> b) & 1);
        end
      end else if (r < 85) begin
        send_bit($urandom_range(1));
      end else if (r < 92) begin
        send_end();
      end else if (r < 95) begin
        send_unused();
      end else begin
        send_item(random_item(FuncLoad));
      end
    end
    send_end();
  endtask

  task automatic test_register_access();
    program_entries(0);
    program_entries(511);
    program_entries(TableDepth);
    program_entries(0);
  endtask

  task automatic test_directed_codes();
    send_load(0, 8'hFF, 1, 16'hFFFF);
    send_load(1, 8'h00, 2, 16'h0000);
    send_load(2, 8'h5A, 0, 16'h0000);
    send_load(3, 8'h3C, 31, 16'h0001);
    send_load(4, 8'h77, 2, 16'h0000);
    send_load(255, 8'h81, 16, 16'h8001);
    settle();
    program_entries(5);
    send_bit(1);
    send_bit(0);
    send_bit(0);
    send_end();
    send_unused();
    send_bit(0);
    send_end();
    // No searched slot matches a zero followed by ones, so this runs out of length.
    send_bit(0);
    repeat (MaxCodeLen - 1) send_bit(1);
    settle();
  endtask

  task automatic test_full_table();
    run_phase(TableDepth, TableDepth, 150);
    run_phase(TableDepth, 511, 150);
    settle();
  endtask

  task automatic test_random_streams();
    int n;
    int unsigned entries;
    int phase;
    phase = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(64, 25);
      end else begin
        n = $urandom_range(16, 1);
      end
      if (phase == 1) begin
        entries = 0;
      end else if ($urandom_range(99) < 75) begin
        entries = n;
      end else begin
        entries = $urandom_range(n, 0);
      end
      steady = (phase == 0);
      run_phase(n, entries, 100);
      settle();
      phase++;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin : check_output
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decode_results_q.size() == 0) begin
        note_failure($sformatf("unexpected output symbol %02h status %0d",
                               out_data.symbol, out_data.status));
      end else begin
        want = decode_results_q.pop_front();
        results_checked++;
        if (out_data.symbol !== want.symbol || out_data.status !== want.status) begin
          note_failure($sformatf("symbol exp %02h got %02h, status exp %0d got %0d",
                                 want.symbol, out_data.symbol, want.status, out_data.status));
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_codes();
    test_full_table();
    test_random_streams();
    settle();
    $display("summary: %0d items sent, %0d decoder outputs checked, %0d table settings",
             items_sent, results_checked, table_settings);
    $display("summary: full and partial tables, duplicate codes, dead slots, %0d errors",
             errors);
    if (errors == 0 && decode_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
